[rtl/lavm_pkg.sv]
// lavm_pkg: payload structs and vector type for the look-at view matrix block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lavm_pkg;

  localparam int WORD_W = 32;

  typedef logic [2:0][WORD_W-1:0] vec_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] eye_x;
    logic signed [WORD_W-1:0] eye_y;
    logic signed [WORD_W-1:0] eye_z;
    logic signed [WORD_W-1:0] target_x;
    logic signed [WORD_W-1:0] target_y;
    logic signed [WORD_W-1:0] target_z;
    logic signed [WORD_W-1:0] up_x;
    logic signed [WORD_W-1:0] up_y;
    logic signed [WORD_W-1:0] up_z;
  } in_t;

  typedef struct packed {
    logic [1:0]               row_number;
    logic signed [WORD_W-1:0] col_zero;
    logic signed [WORD_W-1:0] col_one;
    logic signed [WORD_W-1:0] col_two;
    logic signed [WORD_W-1:0] col_three;
    logic                     last_row;
    logic                     degenerate;
  } out_t;

endpackage
`default_nettype wire

[rtl/lavm_norm.sv]
// lavm_norm: pipelined vector normalizer, squares, bitwise root, long division
// depends on lavm_pkg
`timescale 1ns / 1ps
`default_nettype none
module lavm_norm #(
  parameter int FRAC_BITS = 16,
  parameter int SW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [31:0]          limit,
  input  wire logic                 in_valid,
  input  wire lavm_pkg::vec_t       in_vec,
  input  wire logic                 in_deg,
  input  wire logic [SW-1:0]        in_side,
  output      logic                 out_valid,
  output      lavm_pkg::vec_t       out_vec,
  output      logic                 out_deg,
  output      logic [SW-1:0]        out_side
);
  import lavm_pkg::*;

  localparam int RT = 32;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = 33 + FRAC_BITS;

  logic [2:0][31:0] mag_c;
  logic [2:0][63:0] sq_c;

  logic             v1;
  logic             d1;
  logic [SW-1:0]    side1;
  logic [2:0][31:0] mag1;
  logic [2:0]       neg1;
  logic [2:0][63:0] sq1;

  logic             sv    [0:RT];
  logic             sd    [0:RT];
  logic [SW-1:0]    sside [0:RT];
  logic [2:0][31:0] smag  [0:RT];
  logic [2:0]       sneg  [0:RT];
  logic [63:0]      sr    [0:RT];
  logic [63:0]      rr    [0:RT];

  logic             dv    [0:QW];
  logic             dd    [0:QW];
  logic [SW-1:0]    dside [0:QW];
  logic [2:0]       dneg  [0:QW];
  logic [31:0]      dlen  [0:QW];
  logic [2:0][NW-1:0] dr  [0:QW];
  logic [2:0][QW-1:0] dq  [0:QW];

  logic [63:0] sum_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][31] ? (~in_vec[i] + 32'd1) : in_vec[i];
      sq_c[i]  = mag_c[i] * mag_c[i];
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      d1    <= in_deg;
      side1 <= in_side;
      mag1  <= mag_c;
      sq1   <= sq_c;
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_vec[i][31];
      end
    end
  end

  // sum and degeneracy test
  assign sum_c = sq1[0] + sq1[1] + sq1[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v1;
    end
    if (en) begin
      sd[0]    <= d1 | (sum_c <= {32'd0, limit});
      sside[0] <= side1;
      smag[0]  <= mag1;
      sneg[0]  <= neg1;
      sr[0]    <= sum_c;
      rr[0]    <= 64'd0;
    end
  end

  // integer square root, one root bit per stage
  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = rr[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
      if (en) begin
        sd[k+1]    <= sd[k];
        sside[k+1] <= sside[k];
        smag[k+1]  <= smag[k];
        sneg[k+1]  <= sneg[k];
        if (sr[k] >= trial) begin
          sr[k+1] <= sr[k] - trial;
          rr[k+1] <= (rr[k] >> 1) + BIT;
        end else begin
          sr[k+1] <= sr[k];
          rr[k+1] <= rr[k] >> 1;
        end
      end
    end
  end

  // rounded numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[RT];
    end
    if (en) begin
      dd[0]    <= sd[RT];
      dside[0] <= sside[RT];
      dneg[0]  <= sneg[RT];
      dlen[0]  <= rr[RT][31:0];
      for (int i = 0; i < 3; i++) begin
        dr[0][i] <= NW'({smag[RT][i], {FRAC_BITS{1'b0}}}) + NW'(rr[RT][31:1]);
        dq[0][i] <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NW-1:0] trial;
    assign trial = NW'(dlen[j]) << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
      if (en) begin
        dd[j+1]    <= dd[j];
        dside[j+1] <= dside[j];
        dneg[j+1]  <= dneg[j];
        dlen[j+1]  <= dlen[j];
        for (int i = 0; i < 3; i++) begin
          if (dr[j][i] >= trial) begin
            dr[j+1][i] <= dr[j][i] - trial;
          end else begin
            dr[j+1][i] <= dr[j][i];
          end
          dq[j+1][i] <= dq[j][i] | (QW'(dr[j][i] >= trial) << B);
        end
      end
    end
  end

  // sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
    if (en) begin
      out_deg  <= dd[QW];
      out_side <= dside[QW];
      for (int i = 0; i < 3; i++) begin
        out_vec[i] <= dneg[QW][i] ? -32'(dq[QW][i]) : 32'(dq[QW][i]);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lavm_cross.sv]
// lavm_cross: two-stage cross product a x b, rounded and saturated to 32 bits
// depends on lavm_pkg
`timescale 1ns / 1ps
`default_nettype none
module lavm_cross #(
  parameter int FRAC_BITS = 16,
  parameter int SW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire lavm_pkg::vec_t a,
  input  wire lavm_pkg::vec_t b,
  input  wire logic [SW-1:0]  in_side,
  output      logic           out_valid,
  output      lavm_pkg::vec_t out_vec,
  output      logic [SW-1:0]  out_side
);
  import lavm_pkg::*;

  logic signed [63:0] p [0:5];
  logic               v1;
  logic [SW-1:0]      side1;

  function automatic logic [31:0] round_sat(input logic signed [64:0] v);
    logic [64:0]        m;
    logic signed [64:0] r;
    m = v[64] ? 65'(-v) : 65'(v);
    m = (m + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    r = v[64] ? -$signed(m) : $signed(m);
    if (r > 65'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (r < -65'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      side1 <= in_side;
      p[0]  <= $signed(a[1]) * $signed(b[2]);
      p[1]  <= $signed(a[2]) * $signed(b[1]);
      p[2]  <= $signed(a[2]) * $signed(b[0]);
      p[3]  <= $signed(a[0]) * $signed(b[2]);
      p[4]  <= $signed(a[0]) * $signed(b[1]);
      p[5]  <= $signed(a[1]) * $signed(b[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_side   <= side1;
      out_vec[0] <= round_sat(65'(p[0]) - 65'(p[1]));
      out_vec[1] <= round_sat(65'(p[2]) - 65'(p[3]));
      out_vec[2] <= round_sat(65'(p[4]) - 65'(p[5]));
    end
  end

endmodule
`default_nettype wire

[rtl/lavm_emit.sv]
// lavm_emit: translation terms, row hold register and four-row serializer
// depends on lavm_pkg; drives the pipeline advance enable
`timescale 1ns / 1ps
`default_nettype none
module lavm_emit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  output      logic           en,
  input  wire logic           in_valid,
  input  wire lavm_pkg::vec_t ax_x,
  input  wire lavm_pkg::vec_t ax_y,
  input  wire lavm_pkg::vec_t ax_z,
  input  wire lavm_pkg::vec_t eye,
  input  wire logic           in_deg,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      lavm_pkg::out_t out_data
);
  import lavm_pkg::*;

  logic               v1, v2, v3;
  logic               d1, d2, d3;
  vec_t               x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic signed [63:0] p [0:2][0:2];
  logic signed [65:0] s2 [0:2];
  logic [2:0][31:0]   t3;

  logic               hold_v;
  logic [1:0]         row;
  vec_t               hx, hy, hz;
  logic [2:0][31:0]   ht;
  logic               hdeg;
  logic               last;

  function automatic logic [31:0] neg_round_sat(input logic signed [65:0] v);
    logic [65:0]        m;
    logic signed [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    r = v[65] ? $signed(m) : -$signed(m);
    if (r > 66'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (r < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  assign last = hdeg | (row == 2'd3);
  assign en   = ~hold_v | (out_ready & last);

  // axis times eye products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      d1 <= in_deg;
      x1 <= ax_x;
      y1 <= ax_y;
      z1 <= ax_z;
      for (int c = 0; c < 3; c++) begin
        p[0][c] <= $signed(ax_x[c]) * $signed(eye[c]);
        p[1][c] <= $signed(ax_y[c]) * $signed(eye[c]);
        p[2][c] <= $signed(ax_z[c]) * $signed(eye[c]);
      end
    end
  end

  // dot sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      d2 <= d1;
      x2 <= x1;
      y2 <= y1;
      z2 <= z1;
      for (int r = 0; r < 3; r++) begin
        s2[r] <= 66'(p[r][0]) + 66'(p[r][1]) + 66'(p[r][2]);
      end
    end
  end

  // round, negate, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      d3 <= d2;
      x3 <= x2;
      y3 <= y2;
      z3 <= z2;
      for (int r = 0; r < 3; r++) begin
        t3[r] <= neg_round_sat(s2[r]);
      end
    end
  end

  // hold and row sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      row    <= 2'd0;
    end else if (en) begin
      hold_v <= v3;
      row    <= 2'd0;
    end else if (out_ready) begin
      row <= row + 2'd1;
    end
    if (en) begin
      hx   <= x3;
      hy   <= y3;
      hz   <= z3;
      ht   <= t3;
      hdeg <= d3;
    end
  end

  assign out_valid = hold_v;

  always_comb begin
    out_data            = '0;
    out_data.row_number = row;
    out_data.last_row   = last;
    out_data.degenerate = hdeg;
    if (hdeg) begin
      out_data.row_number = 2'd0;
    end else begin
      case (row)
        2'd0: begin
          out_data.col_zero  = hx[0];
          out_data.col_one   = hx[1];
          out_data.col_two   = hx[2];
          out_data.col_three = ht[0];
        end
        2'd1: begin
          out_data.col_zero  = hy[0];
          out_data.col_one   = hy[1];
          out_data.col_two   = hy[2];
          out_data.col_three = ht[1];
        end
        2'd2: begin
          out_data.col_zero  = hz[0];
          out_data.col_one   = hz[1];
          out_data.col_two   = hz[2];
          out_data.col_three = ht[2];
        end
        default: begin
          out_data.col_three = 32'(64'd1 << FRAC_BITS);
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/look_at_view_matrix.sv]
// look_at_view_matrix: fully pipelined look-at view matrix, one item per cycle
// into the pipeline unless stalled; four row items (one if degenerate) out of the
// serializer; words are signed Q16.16 at the default FRAC_BITS
// throughput: a new item waits until every row of the held one is taken; one per
// cycle when degenerate, set by the single result channel; stalls freeze all
// reset: synchronous, clears all valid bits and sets limit to 0
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire lavm_pkg::in_t  in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      lavm_pkg::out_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata
);
  import lavm_pkg::*;

  logic        en;
  logic [31:0] limit;

  logic        fv;
  vec_t        fd, feye, fup;
  logic [32:0] diff [0:2];

  logic        zn_v, zn_deg;
  vec_t        zn_vec;
  logic [191:0] zn_side;

  logic        c1_v;
  vec_t        c1_vec;
  logic [192:0] c1_side;

  logic        xn_v, xn_deg;
  vec_t        xn_vec;
  logic [191:0] xn_side;

  logic        c2_v;
  vec_t        c2_vec;
  logic [288:0] c2_side;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 32'd0;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  assign diff[0] = 33'(in_data.eye_x) - 33'(in_data.target_x);
  assign diff[1] = 33'(in_data.eye_y) - 33'(in_data.target_y);
  assign diff[2] = 33'(in_data.eye_z) - 33'(in_data.target_z);

  // eye minus target
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fd[i] <= sat33(diff[i]);
      end
      feye <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
      fup  <= {in_data.up_z, in_data.up_y, in_data.up_x};
    end
  end

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .SW(192)) u_norm_z (
    .clk(clk), .rst(rst), .en(en), .limit(limit),
    .in_valid(fv), .in_vec(fd), .in_deg(1'b0), .in_side({fup, feye}),
    .out_valid(zn_v), .out_vec(zn_vec), .out_deg(zn_deg), .out_side(zn_side)
  );

  lavm_cross #(.FRAC_BITS(FRAC_BITS), .SW(193)) u_cross_up_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(zn_v), .a(zn_side[191:96]), .b(zn_vec),
    .in_side({zn_vec, zn_side[95:0], zn_deg}),
    .out_valid(c1_v), .out_vec(c1_vec), .out_side(c1_side)
  );

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .SW(192)) u_norm_x (
    .clk(clk), .rst(rst), .en(en), .limit(limit),
    .in_valid(c1_v), .in_vec(c1_vec), .in_deg(c1_side[0]), .in_side(c1_side[192:1]),
    .out_valid(xn_v), .out_vec(xn_vec), .out_deg(xn_deg), .out_side(xn_side)
  );

  lavm_cross #(.FRAC_BITS(FRAC_BITS), .SW(289)) u_cross_z_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(xn_v), .a(xn_side[191:96]), .b(xn_vec),
    .in_side({xn_vec, xn_side, xn_deg}),
    .out_valid(c2_v), .out_vec(c2_vec), .out_side(c2_side)
  );

  lavm_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c2_v),
    .ax_x(c2_side[288:193]), .ax_y(c2_vec), .ax_z(c2_side[192:97]),
    .eye(c2_side[96:1]), .in_deg(c2_side[0]),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  assign in_ready = en;

endmodule
`default_nettype wire

[rtl/lavm_checker.sv]
// lavm_checker: port-level assertions on row sequencing and stalls
// depends on lavm_pkg; bound to look_at_view_matrix
`timescale 1ns / 1ps
`default_nettype none
module lavm_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire lavm_pkg::out_t out_data
);
  import lavm_pkg::*;

  // rows of one item follow each other directly
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_row) |=>
      (out_valid && out_data.row_number == $past(out_data.row_number) + 2'd1))
    else $error("row sequence broken");

  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.last_row && out_data.row_number == 2'd0 && out_data.col_zero == 0 &&
       out_data.col_one == 0 && out_data.col_two == 0 && out_data.col_three == 0))
    else $error("bad degenerate item");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.degenerate && out_data.last_row) |->
      (out_data.row_number == 2'd3 && out_data.col_three == 32'(64'd1 << FRAC_BITS)))
    else $error("bad last row");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output item not held");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during output stall");

endmodule

bind look_at_view_matrix lavm_checker #(.FRAC_BITS(FRAC_BITS)) u_lavm_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
